// ===== rtl/efws_pkg.sv =====
// ----------------------------------------------------------------------------
// efws_pkg
// shared widths, register map and time arithmetic of the earliest free
// worker scheduler
// ----------------------------------------------------------------------------
package efws_pkg;

   localparam int MAX_WORKERS = 64;
   localparam int TIME_W      = 48;
   localparam int DUR_W       = 32;
   localparam int COUNT_W     = 7;
   localparam int WORKER_W    = 6;
   localparam int CSR_W       = 32;
   localparam int PADDR_W     = 3;

   localparam logic [TIME_W-1:0]  TIME_MAX      = {TIME_W{1'b1}};
   localparam logic [COUNT_W-1:0] RESET_WORKERS = 7'd4;

   // register index, taken from paddr[2]
   localparam logic REG_WORKER_COUNT = 1'b0;

   typedef struct packed {
      logic              sat;
      logic [TIME_W-1:0] value;
   } sum_type;

   // free time plus duration, clipped at the largest time
   function automatic sum_type sat_add(input logic [TIME_W-1:0] t,
                                       input logic [DUR_W-1:0]  d);
      logic [TIME_W:0] full;
      sum_type         res;
      full = {1'b0, t} + {{(TIME_W + 1 - DUR_W){1'b0}}, d};
      res.sat   = full[TIME_W];
      res.value = full[TIME_W] ? TIME_MAX : full[TIME_W-1:0];
      return res;
   endfunction

endpackage

// ===== rtl/earliest_free_worker_scheduler.sv =====
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler
// assigns each job to the worker that becomes free earliest (lowest index on
// a tie) using a min-heap of (free time, worker) in a 1-write 2-read ram
//
//   channel  direction  transfer when          payload
//   req      in         req_valid & req_ready  req_duration
//   rsp      out        rsp_valid & rsp_ready  rsp_worker, rsp_start_time,
//                                              rsp_saturated
//   csr      in/out     psel & penable & pready  paddr, pwdata, prdata
//
// from one accept to the next a job passes the idle, root, sift-down and
// finish states, the sift-down taking one heap level per cycle on the ram
// read port pair down to a depth set by the active worker count.
// after reset and after every worker_count write a clearing pass rewrites
// all MAX_WORKERS heap entries, one per cycle, with req_ready low.
// a result waits in the output register while the next job is taken; the
// heap stalls at its final step only if that register is still full.
// ----------------------------------------------------------------------------
module earliest_free_worker_scheduler
   import efws_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [DUR_W-1:0]    req_duration,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORKER_W-1:0] rsp_worker,
   output logic [TIME_W-1:0]   rsp_start_time,
   output logic                rsp_saturated,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [CSR_W-1:0]    pwdata,
   output logic [CSR_W-1:0]    prdata,
   output logic                pready
);

   localparam int IDX_W   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int CNT_W   = $clog2(MAX_WORKERS + 1);
   localparam int CH_W    = IDX_W + 2;
   localparam int ENTRY_W = TIME_W + IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_WORKERS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROOT,
      ST_SIFT,
      ST_FINISH
   } state_type;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
      logic [CNT_W-1:0] n;
      if (v == '0) begin
         n = CNT_W'(1);
      end else if (int'(v) > MAX_WORKERS) begin
         n = CNT_W'(MAX_WORKERS);
      end else begin
         n = CNT_W'(v);
      end
      return n;
   endfunction

   state_type           state_ff;
   logic [IDX_W-1:0]    clr_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]    active_ff;
   logic [DUR_W-1:0]    dur_ff;
   logic [ENTRY_W-1:0]  key_ff;
   logic [IDX_W-1:0]    cur_ff;
   logic                lvalid_ff;
   logic                rvalid_ff;
   logic [TIME_W-1:0]   pend_start_ff;
   logic                pend_sat_ff;
   logic                rsp_valid_ff;
   logic [WORKER_W-1:0] rsp_worker_ff;
   logic [TIME_W-1:0]   rsp_start_ff;
   logic                rsp_sat_ff;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic [IDX_W-1:0]    rd_addr_a;
   logic [IDX_W-1:0]    rd_addr_a_mux;
   logic [IDX_W-1:0]    rd_addr_b;
   logic [ENTRY_W-1:0]  rd_data_a;
   logic [ENTRY_W-1:0]  rd_data_b;

   logic                cfg_wr;
   logic                req_xfer;
   logic                slot_free;
   logic                rsp_load;
   logic [CH_W-1:0]     cur_l;
   logic [CH_W-1:0]     cur_r;
   logic                take_r;
   logic [ENTRY_W-1:0]  pick_data;
   logic [IDX_W-1:0]    pick_idx;
   logic                descend;
   logic [IDX_W-1:0]    ch_base;
   logic [CH_W-1:0]     nxt_l;
   logic [CH_W-1:0]     nxt_r;
   sum_type             root_sum;

   assign cfg_wr    = psel && penable && pwrite && paddr[2] == REG_WORKER_COUNT;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_WORKER_COUNT) ? CSR_W'(count_ff) : '0;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == ST_FINISH) && slot_free;

   // children of the current heap slot and the smaller of them
   assign cur_l     = {1'b0, cur_ff, 1'b1};
   assign cur_r     = {1'b0, cur_ff, 1'b0} + CH_W'(2);
   assign take_r    = rvalid_ff && (rd_data_b < rd_data_a);
   assign pick_data = take_r ? rd_data_b : rd_data_a;
   assign pick_idx  = take_r ? cur_r[IDX_W-1:0] : cur_l[IDX_W-1:0];
   assign descend   = lvalid_ff && (pick_data < key_ff);

   // children of the slot visited next
   assign ch_base   = (state_ff == ST_SIFT) ? pick_idx : '0;
   assign nxt_l     = {1'b0, ch_base, 1'b1};
   assign nxt_r     = {1'b0, ch_base, 1'b0} + CH_W'(2);
   assign rd_addr_a = nxt_l[IDX_W-1:0];
   assign rd_addr_b = nxt_r[IDX_W-1:0];

   // in idle the a port fetches the root
   assign rd_addr_a_mux = (state_ff == ST_IDLE) ? '0 : rd_addr_a;

   assign root_sum = sat_add(rd_data_a[ENTRY_W-1:IDX_W], dur_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_ff;
      wr_data = descend ? pick_data : key_ff;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = {{TIME_W{1'b0}}, clr_ff};
      end else if (state_ff == ST_SIFT) begin
         wr_en = 1'b1;
      end
   end

   efws_heap_ram #(
      .DEPTH  (MAX_WORKERS),
      .ADDR_W (IDX_W),
      .DATA_W (ENTRY_W)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a_mux),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= RESET_WORKERS;
         active_ff    <= clamp_count(RESET_WORKERS);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_worker_ff <= WORKER_W'(key_ff[IDX_W-1:0]);
            rsp_start_ff  <= pend_start_ff;
            rsp_sat_ff    <= pend_sat_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cfg_wr) begin
            count_ff  <= pwdata[COUNT_W-1:0];
            active_ff <= clamp_count(pwdata[COUNT_W-1:0]);
            state_ff  <= ST_CLEAR;
            clr_ff    <= '0;
         end else begin
            unique case (state_ff)
               ST_CLEAR: begin
                  clr_ff <= clr_ff + IDX_W'(1);
                  if (clr_ff == LAST_IDX) begin
                     state_ff <= ST_IDLE;
                  end
               end
               ST_IDLE: begin
                  if (req_xfer) begin
                     dur_ff   <= req_duration;
                     state_ff <= ST_ROOT;
                  end
               end
               ST_ROOT: begin
                  key_ff        <= {root_sum.value, rd_data_a[IDX_W-1:0]};
                  pend_start_ff <= rd_data_a[ENTRY_W-1:IDX_W];
                  pend_sat_ff   <= root_sum.sat;
                  cur_ff        <= '0;
                  lvalid_ff     <= nxt_l < CH_W'(active_ff);
                  rvalid_ff     <= nxt_r < CH_W'(active_ff);
                  state_ff      <= ST_SIFT;
               end
               ST_SIFT: begin
                  if (descend) begin
                     cur_ff    <= pick_idx;
                     lvalid_ff <= nxt_l < CH_W'(active_ff);
                     rvalid_ff <= nxt_r < CH_W'(active_ff);
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
               ST_FINISH: begin
                  if (slot_free) begin
                     state_ff <= ST_IDLE;
                  end
               end
               default: begin
                  state_ff <= ST_CLEAR;
                  clr_ff   <= '0;
               end
            endcase
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_worker     = rsp_worker_ff;
   assign rsp_start_time = rsp_start_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule

// ===== rtl/efws_heap_ram.sv =====
// ----------------------------------------------------------------------------
// efws_heap_ram
// heap storage: one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
module efws_heap_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 54
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== dv/earliest_free_worker_scheduler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler_tb
// self-checking bench for the earliest free worker scheduler. a short
// directed table covers reset state, worker count clamping, ignored register
// writes, ties and extreme durations; random phases then rerun the block
// under many worker counts, most with random idling on both channels, and a
// final phase runs back to back with no idling. every result transfer is
// checked against its typed directed row or a local list-scheduling model.
// ----------------------------------------------------------------------------
module earliest_free_worker_scheduler_tb
   import efws_pkg::*;
();

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_JOBS  = 1800;
   localparam int FINAL_JOBS   = 150;
   localparam int DRAIN_CYCLES = 16;

   localparam logic                REG_UNUSED        = 1'b1;
   localparam logic [PADDR_W-1:0] ADDR_WORKER_COUNT = {REG_WORKER_COUNT, 2'b00};
   localparam logic [PADDR_W-1:0] ADDR_UNUSED       = {REG_UNUSED, 2'b00};
   localparam logic [DUR_W-1:0]   DUR_MAX           = {DUR_W{1'b1}};

   typedef enum logic {ROW_JOB, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [WORKER_W-1:0] worker;
      logic [TIME_W-1:0]   start_time;
      logic                saturated;
   } job_result_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [PADDR_W-1:0] addr;
      logic [CSR_W-1:0]   value;
      logic               typed;
      job_result_type     result;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [DUR_W-1:0]    req_duration = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [WORKER_W-1:0] rsp_worker;
   logic [TIME_W-1:0]   rsp_start_time;
   logic                rsp_saturated;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [CSR_W-1:0]    pwdata = '0;
   logic [CSR_W-1:0]    prdata;
   logic                pready;

   // scheduling model state
   logic [COUNT_W-1:0]  model_worker_count;
   logic [TIME_W-1:0]   model_free_time [MAX_WORKERS];
   job_result_type      pending_assignments [$];
   stim_row_type        directed_rows [$];

   int                  mismatches = 0;
   int                  cycle_count = 0;
   bit                  idling_on = 1'b0;
   int                  stall_left = 0;
   logic [DUR_W-1:0]    last_duration = '0;

   earliest_free_worker_scheduler dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_duration   (req_duration),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_worker     (rsp_worker),
      .rsp_start_time (rsp_start_time),
      .rsp_saturated  (rsp_saturated),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #2 clock = ~clock;

   function automatic void clear_schedule();
      for (int i = 0; i < MAX_WORKERS; i++) begin
         model_free_time[i] = '0;
      end
   endfunction

   // earliest free worker among the active ones, lowest index on a tie
   function automatic job_result_type assign_job(input logic [DUR_W-1:0] duration);
      int              n;
      int              best;
      logic [TIME_W:0] sum;
      job_result_type  r;
      n = int'(model_worker_count);
      if (n < 1) n = 1;
      if (n > MAX_WORKERS) n = MAX_WORKERS;
      best = 0;
      for (int i = 1; i < n; i++) begin
         if (model_free_time[i] < model_free_time[best]) best = i;
      end
      sum = {1'b0, model_free_time[best]} + {{(TIME_W + 1 - DUR_W){1'b0}}, duration};
      r.worker     = WORKER_W'(best);
      r.start_time = model_free_time[best];
      r.saturated  = sum[TIME_W];
      model_free_time[best] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      return r;
   endfunction

   function automatic logic [DUR_W-1:0] pick_duration();
      logic [DUR_W-1:0] d;
      case ($urandom_range(0, 9))
         0:       d = '0;
         1:       d = DUR_MAX;
         2, 3:    d = DUR_W'($urandom_range(0, 15));
         4:       d = last_duration;
         5:       d = DUR_W'(1) << $urandom_range(0, DUR_W - 1);
         6:       d = DUR_MAX - DUR_W'($urandom_range(0, 15));
         default: d = $urandom;
      endcase
      last_duration = d;
      return d;
   endfunction

   function automatic void add_job(input logic [DUR_W-1:0] d);
      stim_row_type row;
      row = '0;
      row.kind  = ROW_JOB;
      row.value = d;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_job_typed(input logic [DUR_W-1:0] d,
                                         input int w, input longint s);
      stim_row_type row;
      row = '0;
      row.kind              = ROW_JOB;
      row.value             = d;
      row.typed             = 1'b1;
      row.result.worker     = WORKER_W'(w);
      row.result.start_time = TIME_W'(s);
      row.result.saturated  = 1'b0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [PADDR_W-1:0] a, input logic [CSR_W-1:0] v);
      stim_row_type row;
      row = '0;
      row.kind  = ROW_CSR;
      row.addr  = a;
      row.value = v;
      directed_rows.push_back(row);
   endfunction

   task automatic send_job(input logic [DUR_W-1:0] d, input logic typed,
                           input job_result_type typed_result);
      job_result_type r;
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_duration <= d;
      do @(posedge clock); while (!req_ready);
      r = assign_job(d);
      pending_assignments.push_back(typed ? typed_result : r);
   endtask

   // let every outstanding result arrive before touching the register
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_assignments.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [PADDR_W-1:0] a, input logic [CSR_W-1:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= a;
      pwdata  <= v;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (a[2] == REG_WORKER_COUNT) begin
         model_worker_count = v[COUNT_W-1:0];
         clear_schedule();
      end
   endtask

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result channel back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idling_on && $urandom_range(0, 15) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // result transfer check
   always @(posedge clock) begin
      job_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_assignments.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("unexpected result: worker %0d start %0d sat %0b",
                        rsp_worker, rsp_start_time, rsp_saturated);
         end else begin
            exp_r = pending_assignments.pop_front();
            if (rsp_worker !== exp_r.worker || rsp_start_time !== exp_r.start_time ||
                rsp_saturated !== exp_r.saturated) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: exp worker %0d start %0d sat %0b, got %0d %0d %0b",
                           exp_r.worker, exp_r.start_time, exp_r.saturated,
                           rsp_worker, rsp_start_time, rsp_saturated);
            end
         end
      end
   end

   initial begin
      int               sent;
      int               phase_jobs;
      int               count_value;
      job_result_type   no_result;
      stim_row_type     row;

      no_result          = '0;
      model_worker_count = RESET_WORKERS;
      clear_schedule();

      // reset state, four workers
      add_job_typed(32'd5, 0, 0);
      add_job_typed(32'd0, 1, 0);
      add_job_typed(DUR_MAX, 1, 0);
      add_job_typed(32'd3, 2, 0);
      add_job_typed(32'd1, 3, 0);
      add_job(32'd2);
      // zero count means one worker
      add_csr(ADDR_WORKER_COUNT, 32'd0);
      add_job_typed(32'd7, 0, 0);
      add_job_typed(DUR_MAX, 0, 7);
      add_job(32'd0);
      // count above the maximum clamps
      add_csr(ADDR_WORKER_COUNT, 32'd127);
      add_job_typed(32'd0, 0, 0);
      add_job_typed(32'd0, 0, 0);
      add_job_typed(32'd9, 0, 0);
      add_job_typed(32'd9, 1, 0);
      // unknown register leaves the schedule alone
      add_csr(ADDR_UNUSED, 32'd1);
      add_job_typed(32'd0, 2, 0);
      // equal free times go to the lower index
      add_csr(ADDR_WORKER_COUNT, 32'd2);
      add_job_typed(32'd10, 0, 0);
      add_job_typed(32'd10, 1, 0);
      add_job_typed(32'd4, 0, 10);
      add_job_typed(32'd6, 1, 10);
      add_job(32'd0);
      add_csr(ADDR_WORKER_COUNT, 32'd64);
      add_job(DUR_MAX);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      idling_on = 1'b1;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            drain();
            csr_write(row.addr, row.value);
         end else begin
            send_job(row.value[DUR_W-1:0], row.typed, row.result);
         end
      end

      // random phases over many worker counts
      sent = 0;
      while (sent < RANDOM_JOBS) begin
         case ($urandom_range(0, 7))
            0:       count_value = 1;
            1:       count_value = 2;
            2:       count_value = MAX_WORKERS;
            3:       count_value = 0;
            4:       count_value = $urandom_range(65, 127);
            default: count_value = $urandom_range(1, MAX_WORKERS);
         endcase
         drain();
         if ($urandom_range(0, 5) == 0) csr_write(ADDR_UNUSED, $urandom);
         csr_write(ADDR_WORKER_COUNT, CSR_W'(count_value));
         idling_on  = ($urandom_range(0, 3) != 0);
         phase_jobs = $urandom_range(50, 250);
         for (int j = 0; j < phase_jobs; j++) begin
            send_job(pick_duration(), 1'b0, no_result);
         end
         sent += phase_jobs;
      end

      // all workers, back to back with no idling
      drain();
      idling_on = 1'b0;
      csr_write(ADDR_WORKER_COUNT, CSR_W'(MAX_WORKERS));
      for (int j = 0; j < FINAL_JOBS; j++) begin
         send_job(pick_duration(), 1'b0, no_result);
      end

      req_valid <= 1'b0;
      while (pending_assignments.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      if (mismatches == 0 && pending_assignments.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== earliest_free_worker_scheduler.f =====
rtl/efws_pkg.sv
rtl/efws_heap_ram.sv
rtl/earliest_free_worker_scheduler.sv
dv/earliest_free_worker_scheduler_tb.sv
